// File: hw/rtl/assert_macros.svh
// assertion macros used by the frame receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define CHK_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed: always");
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: implication");
`else
`define CHK_ALWAYS(lbl, clk, rst, expr)
`define CHK_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/sefr_pkg.sv
// types and constants for the framed byte receiver
`default_nettype none

package sefr_pkg;

  localparam int BUFFER_BYTES_DEF  = 1024;
  localparam int HISTORY_DEPTH_DEF = 100;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;
  localparam logic [7:0] SEP_RESET  = 8'h7C;
  localparam logic [9:0] FIELD_MAX  = 10'h3FF;

  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHECK_END = 1'b0,
    REG_FIELD_SEP = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_PAYLOAD   = 4'd0,
    ST_START     = 4'd1,
    ST_END_WAIT  = 4'd2,
    ST_GOOD      = 4'd3,
    ST_EMPTY     = 4'd4,
    ST_TOO_LONG  = 4'd5,
    ST_MISMATCH  = 4'd6,
    ST_OVERFLOW  = 4'd7,
    ST_CHK_MISS  = 4'd8,
    ST_CHUNK_END = 4'd9
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/stx_etx_lrc_frame_receiver.sv
// framed byte receiver with xor check, field counting and good-frame history
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | rx_byte, last_in_chunk
//  out     | out_valid/ out_ready | status, byte_echo, field_index, payload_count,
//          |                      | check_value, frames_stored, history_full
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// one item per cycle while in_ready is high: the frame state is updated as the item is
// taken and the result lands in the output register.
// in_ready drops only while a result waits in the output register and out_ready is low.
// cfg_ready is always high.
// synchronous reset clears frame state, history count and out_valid and sets the config registers to defaults.
`default_nettype none

`include "assert_macros.svh"

module stx_etx_lrc_frame_receiver
  import sefr_pkg::*;
#(
  parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   last_in_chunk,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [3:0]                  status,
  output logic [7:0]                  byte_echo,
  output logic [9:0]                  field_index,
  output logic [9:0]                  payload_count,
  output logic [7:0]                  check_value,
  output logic [6:0]                  frames_stored,
  output logic                        history_full,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data
);

  localparam int CW = $clog2(BUFFER_BYTES);
  localparam int SW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] COUNT_LIMIT = CW'(BUFFER_BYTES - 1);
  localparam logic [SW-1:0] HIST_LIMIT  = SW'(HISTORY_DEPTH);

  // configuration
  logic       check_end;
  logic [7:0] field_sep;

  // frame state
  logic          awaiting_check;
  logic [CW-1:0] byte_count;
  logic [7:0]    running_check;
  logic [9:0]    field_total;
  logic          after_separator;
  logic          zero_byte_seen;
  logic [SW-1:0] stored_frames;

  // values after this item, before any frame clear
  logic          upd_awaiting;
  logic [CW-1:0] upd_count;
  logic [7:0]    upd_check;
  logic [9:0]    upd_field;
  logic          upd_after_sep;
  logic          upd_zero_seen;
  logic [SW-1:0] stored_frames_next;
  status_t       res_status;
  logic          res_full;
  logic          done;
  logic          count_full;
  logic [7:0]    expect_check;
  logic [31:0]   count_wide;
  logic [31:0]   stored_wide;
  logic          in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign count_full   = byte_count >= COUNT_LIMIT;
  assign expect_check = running_check ^ (check_end ? END_BYTE : 8'h00);

  always_comb begin
    upd_awaiting       = awaiting_check;
    upd_count          = byte_count;
    upd_check          = running_check;
    upd_field          = field_total;
    upd_after_sep      = after_separator;
    upd_zero_seen      = zero_byte_seen;
    stored_frames_next = stored_frames;
    res_status         = ST_PAYLOAD;
    res_full           = 1'b0;
    done               = 1'b0;
    if (awaiting_check) begin
      done = 1'b1;
      if (rx_byte == expect_check) begin
        res_status = ST_GOOD;
        if (stored_frames < HIST_LIMIT) begin
          stored_frames_next = stored_frames + SW'(1);
        end else begin
          res_full = 1'b1;
        end
      end else begin
        res_status = ST_MISMATCH;
      end
    end else if (rx_byte == START_BYTE) begin
      upd_count     = '0;
      upd_check     = '0;
      upd_field     = '0;
      upd_after_sep = 1'b1;
      upd_zero_seen = 1'b0;
      res_status    = ST_START;
      if (last_in_chunk) begin
        res_status = ST_CHUNK_END;
        done       = 1'b1;
      end
    end else if (rx_byte == END_BYTE) begin
      if (byte_count == '0) begin
        res_status = ST_EMPTY;
        done       = 1'b1;
      end else if (count_full) begin
        res_status = ST_TOO_LONG;
        done       = 1'b1;
      end else if (last_in_chunk) begin
        res_status = ST_CHK_MISS;
        done       = 1'b1;
      end else begin
        res_status   = ST_END_WAIT;
        upd_awaiting = 1'b1;
      end
    end else if (count_full) begin
      res_status = ST_OVERFLOW;
      done       = 1'b1;
    end else begin
      upd_count = byte_count + CW'(1);
      upd_check = running_check ^ rx_byte;
      // field counting stops after a zero byte until the frame state is cleared
      if (!zero_byte_seen) begin
        if (rx_byte == 8'h00) begin
          upd_zero_seen = 1'b1;
        end else if (rx_byte == field_sep) begin
          upd_after_sep = 1'b1;
        end else if (after_separator) begin
          upd_after_sep = 1'b0;
          if (field_total != FIELD_MAX) begin
            upd_field = field_total + 10'd1;
          end
        end
      end
      if (last_in_chunk) begin
        res_status = ST_CHUNK_END;
        done       = 1'b1;
      end
    end
  end

  assign count_wide  = 32'(upd_count);
  assign stored_wide = 32'(stored_frames_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      check_end <= 1'b0;
      field_sep <= SEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHECK_END: check_end <= cfg_data[0];
        REG_FIELD_SEP: field_sep <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_check  <= 1'b0;
      byte_count      <= '0;
      running_check   <= '0;
      field_total     <= '0;
      after_separator <= 1'b1;
      zero_byte_seen  <= 1'b0;
      stored_frames   <= '0;
    end else if (in_fire) begin
      stored_frames <= stored_frames_next;
      if (done) begin
        awaiting_check  <= 1'b0;
        byte_count      <= '0;
        running_check   <= '0;
        field_total     <= '0;
        after_separator <= 1'b1;
        zero_byte_seen  <= 1'b0;
      end else begin
        awaiting_check  <= upd_awaiting;
        byte_count      <= upd_count;
        running_check   <= upd_check;
        field_total     <= upd_field;
        after_separator <= upd_after_sep;
        zero_byte_seen  <= upd_zero_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status        <= res_status;
      byte_echo     <= rx_byte;
      field_index   <= upd_field;
      payload_count <= count_wide[9:0];
      check_value   <= upd_check;
      frames_stored <= stored_wide[6:0];
      history_full  <= res_full;
    end
  end

  `CHK_ALWAYS(a_hist_bound, clk, rst, stored_frames <= HIST_LIMIT)
  `CHK_ALWAYS(a_count_bound, clk, rst, byte_count <= COUNT_LIMIT)
  `CHK_IMPL(a_full_on_good, clk, rst, out_valid && history_full, status == ST_GOOD)
  `CHK_IMPL(a_wait_after_end, clk, rst, $rose(awaiting_check), out_valid && status == ST_END_WAIT)

endmodule

`default_nettype wire
